@@ sv/tcq_pkg.sv @@
`default_nettype none
package tcq_pkg;
  localparam logic [2:0] FUNC_ADD    = 3'd0;
  localparam logic [2:0] FUNC_POP    = 3'd1;
  localparam logic [2:0] FUNC_QUERY  = 3'd2;
  localparam logic [2:0] FUNC_CANCEL = 3'd3;
  localparam logic [2:0] FUNC_CLEAR  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NONE    = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef logic [2:0] cell_op_t;
  localparam cell_op_t OP_HOLD  = 3'd0;
  localparam cell_op_t OP_NEW   = 3'd1;
  localparam cell_op_t OP_LEFT  = 3'd2;
  localparam cell_op_t OP_RIGHT = 3'd3;
  localparam cell_op_t OP_OWN   = 3'd4;

  localparam logic [63:0] NO_OWNER_TIME = 64'h0000_0000_FFFF_FFFF;
endpackage
`default_nettype wire

@@ sv/two_class_dedupe_rate_limited_queue.sv @@
// Each transfer passes through accept, match, act and deliver; a query that finds its
// owner adds Q1 and Q2; a manual add that moves an automatic entry repeats match and act.
// The match and shift work is done by a row of cells, one per queue entry.
// One request is processed at a time; the next is accepted once the result is registered.
// Synchronous active-high reset empties the queue, clears the last pop time and
// loads both intervals with 2000; entry contents are not cleared.
`default_nettype none
module two_class_dedupe_rate_limited_queue #(
  parameter int QUEUE_DEPTH = 32,
  parameter int OWNER_COUNT = 16,
  parameter int KEY_BITS = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // search_key[31:0], is_auto[32], owner_id[36:33], owner_present[37],
  // now[101:38], is_passive[102], zero[103]
  input  wire logic [103:0] s_tdata,
  // func[2:0]
  input  wire logic [2:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // status[1:0], out_key[33:2], out_auto[34], out_owners[50:35],
  // search_time[114:51], queue_empty[115], zero[119:116]
  output logic [119:0]      m_tdata,
  input  wire logic         cfg_we,
  input  wire logic         cfg_addr,
  input  wire logic [31:0]  cfg_data
);
  localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int OW = OWNER_COUNT;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int PW = CW + 32;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_ACT  = 3'd2;
  localparam logic [2:0] S_Q1   = 3'd3;
  localparam logic [2:0] S_Q2   = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic [1:0] A_NONE = 2'd0;
  localparam logic [1:0] A_INS  = 2'd1;
  localparam logic [1:0] A_REM  = 2'd2;
  localparam logic [1:0] A_OWN  = 2'd3;

  logic [2:0]  state;
  logic [31:0] iv_active;
  logic [31:0] iv_passive;
  logic [63:0] last_pop;
  logic [CW-1:0] count;
  logic        reins;

  logic [2:0]    r_func;
  logic [KW-1:0] r_key;
  logic          r_auto;
  logic [OW-1:0] r_bit;
  logic          r_present;
  logic [63:0]   r_now;
  logic          r_passive;

  logic [KW-1:0] mv_key;
  logic [OW-1:0] mv_owners;

  logic [QUEUE_DEPTH-1:0] km;
  logic [QUEUE_DEPTH-1:0] om;
  logic [QUEUE_DEPTH-1:0] av;
  logic [QUEUE_DEPTH-1:0] km_c;
  logic [QUEUE_DEPTH-1:0] om_c;
  logic [QUEUE_DEPTH-1:0] av_c;

  logic [KW-1:0] c_key    [QUEUE_DEPTH];
  logic          c_auto   [QUEUE_DEPTH];
  logic [OW-1:0] c_owners [QUEUE_DEPTH];
  tcq_pkg::cell_op_t c_op [QUEUE_DEPTH];

  logic [1:0]    act;
  logic [IW-1:0] act_pos;
  logic [KW-1:0] act_key;
  logic          act_auto;
  logic [OW-1:0] act_owners;
  logic [CW-1:0] count_next;
  logic [2:0]    act_state;

  logic [1:0]    res_status;
  logic [KW-1:0] res_key;
  logic          res_auto;
  logic [OW-1:0] res_owners;
  logic [63:0]   res_time;

  logic [IW-1:0] p_key;
  logic [IW-1:0] p_own;
  logic [IW-1:0] p_auto;
  logic [CW-1:0] first_auto;
  logic [31:0]   iv_sel;
  logic          pop_ready;
  logic [CW-1:0] q_k;
  logic [63:0]   q_base;
  logic [PW-1:0] q_prod;
  logic [64:0]   q_sum;
  logic [OW-1:0] cancel_left;

  function automatic logic [IW-1:0] first_idx(input logic [QUEUE_DEPTH-1:0] v);
    logic [IW-1:0] r;
    r = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (v[i]) r = IW'(i);
    end
    return r;
  endfunction

  assign s_tready = (state == S_IDLE);

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      logic [KW-1:0] lk;
      logic          la;
      logic [OW-1:0] lo;
      logic [KW-1:0] rk;
      logic          ra;
      logic [OW-1:0] ro;
      if (g == 0) begin : g_first
        assign lk = '0;
        assign la = 1'b0;
        assign lo = '0;
      end else begin : g_mid
        assign lk = c_key[g-1];
        assign la = c_auto[g-1];
        assign lo = c_owners[g-1];
      end
      if (g == QUEUE_DEPTH - 1) begin : g_last
        assign rk = '0;
        assign ra = 1'b0;
        assign ro = '0;
      end else begin : g_inner
        assign rk = c_key[g+1];
        assign ra = c_auto[g+1];
        assign ro = c_owners[g+1];
      end

      always_comb begin
        c_op[g] = tcq_pkg::OP_HOLD;
        if (state == S_ACT) begin
          unique case (act)
            A_INS: begin
              if (IW'(g) == act_pos) c_op[g] = tcq_pkg::OP_NEW;
              else if (IW'(g) > act_pos && CW'(g) <= count) c_op[g] = tcq_pkg::OP_LEFT;
            end
            A_REM: begin
              if (IW'(g) >= act_pos && CW'(g) + CW'(1) < count) c_op[g] = tcq_pkg::OP_RIGHT;
            end
            A_OWN: begin
              if (IW'(g) == act_pos) c_op[g] = tcq_pkg::OP_OWN;
            end
            default: begin
            end
          endcase
        end
      end

      tcq_cell #(.KW(KW), .OW(OW), .CW(CW), .IDX(g)) u_cell (
        .clk         (clk),
        .op          (c_op[g]),
        .new_key     (act_key),
        .new_auto    (act_auto),
        .new_owners  (act_owners),
        .left_key    (lk),
        .left_auto   (la),
        .left_owners (lo),
        .right_key   (rk),
        .right_auto  (ra),
        .right_owners(ro),
        .req_key     (r_key),
        .req_bit     (r_bit),
        .count       (count),
        .key         (c_key[g]),
        .auto_flag   (c_auto[g]),
        .owners      (c_owners[g]),
        .key_match   (km_c[g]),
        .owner_match (om_c[g]),
        .auto_valid  (av_c[g])
      );
    end
  endgenerate

  assign p_key      = first_idx(km);
  assign p_own      = first_idx(om);
  assign p_auto     = first_idx(av);
  assign first_auto = (av != '0) ? CW'(p_auto) : count;
  assign iv_sel     = r_passive ? iv_passive : iv_active;
  assign pop_ready  = (r_now > last_pop) && ((r_now - last_pop) > {32'd0, iv_sel});
  assign cancel_left = c_owners[p_own] & ~r_bit;
  assign q_sum      = {1'b0, q_base} + 65'(q_prod);

  always_comb begin
    act_state = S_DONE;
    if (!reins && r_func == tcq_pkg::FUNC_ADD && r_bit != '0 && km != '0 &&
        !r_auto && c_auto[p_key]) begin
      act_state = S_EVAL;
    end else if (!reins && r_func == tcq_pkg::FUNC_QUERY && r_present &&
                 r_bit != '0 && om != '0) begin
      act_state = S_Q1;
    end
  end

  always_comb begin
    act        = A_NONE;
    act_pos    = '0;
    act_key    = r_key;
    act_auto   = r_auto;
    act_owners = r_bit;
    count_next = count;
    if (reins) begin
      act        = A_INS;
      act_pos    = IW'(first_auto);
      act_key    = mv_key;
      act_auto   = 1'b0;
      act_owners = mv_owners;
      count_next = count + CW'(1);
    end else begin
      unique case (r_func)
        tcq_pkg::FUNC_ADD: begin
          if (r_bit != '0) begin
            if (km != '0) begin
              act_pos = p_key;
              if (!r_auto && c_auto[p_key]) begin
                act        = A_REM;
                count_next = count - CW'(1);
              end else begin
                act        = A_OWN;
                act_owners = c_owners[p_key] | r_bit;
              end
            end else if (count < CW'(QUEUE_DEPTH)) begin
              act        = A_INS;
              act_pos    = r_auto ? IW'(count) : IW'(first_auto);
              count_next = count + CW'(1);
            end
          end
        end
        tcq_pkg::FUNC_POP: begin
          if (pop_ready && count != '0) begin
            act        = A_REM;
            count_next = count - CW'(1);
          end
        end
        tcq_pkg::FUNC_CANCEL: begin
          if (r_bit != '0 && om != '0) begin
            act_pos = p_own;
            if (cancel_left == '0) begin
              act        = A_REM;
              count_next = count - CW'(1);
            end else begin
              act        = A_OWN;
              act_owners = cancel_left;
            end
          end
        end
        tcq_pkg::FUNC_CLEAR: begin
          count_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      iv_active  <= 32'd2000;
      iv_passive <= 32'd2000;
      last_pop   <= '0;
      count      <= '0;
      reins      <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr) iv_passive <= cfg_data;
        else iv_active <= cfg_data;
      end
      if (m_tvalid && m_tready && state != S_DONE) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            r_func     <= s_tuser;
            r_key      <= s_tdata[KW-1:0];
            r_auto     <= s_tdata[32];
            r_bit      <= ({28'd0, s_tdata[36:33]} < OWNER_COUNT) ?
                          (OW'(1) << s_tdata[36:33]) : '0;
            r_present  <= s_tdata[37];
            r_now      <= s_tdata[101:38];
            r_passive  <= s_tdata[102];
            res_status <= tcq_pkg::ST_NONE;
            res_key    <= '0;
            res_auto   <= 1'b0;
            res_owners <= '0;
            res_time   <= '0;
            state      <= S_EVAL;
          end
        end
        S_EVAL: begin
          km    <= km_c;
          om    <= om_c;
          av    <= av_c;
          state <= S_ACT;
        end
        S_ACT: begin
          count <= count_next;
          state <= act_state;
          if (reins) begin
            reins      <= 1'b0;
            res_status <= tcq_pkg::ST_OK;
          end else begin
            unique case (r_func)
              tcq_pkg::FUNC_ADD: begin
                if (r_bit != '0) begin
                  if (km != '0) begin
                    if (!r_auto && c_auto[p_key]) begin
                      reins     <= 1'b1;
                      mv_key    <= r_key;
                      mv_owners <= c_owners[p_key] | r_bit;
                    end
                  end else if (count < CW'(QUEUE_DEPTH)) begin
                    res_status <= tcq_pkg::ST_OK;
                  end else begin
                    res_status <= tcq_pkg::ST_FULL;
                  end
                end
              end
              tcq_pkg::FUNC_POP: begin
                if (pop_ready && count != '0) begin
                  res_status <= tcq_pkg::ST_OK;
                  res_key    <= c_key[0];
                  res_auto   <= c_auto[0];
                  res_owners <= c_owners[0];
                  last_pop   <= r_now;
                end
              end
              tcq_pkg::FUNC_QUERY: begin
                if (!r_present) begin
                  res_status <= tcq_pkg::ST_OK;
                  res_time   <= tcq_pkg::NO_OWNER_TIME;
                end else if (r_bit != '0 && om != '0) begin
                  q_k    <= CW'(p_own) + CW'(1);
                  q_base <= (r_now >= {32'd0, iv_active}) ?
                            r_now - {32'd0, iv_active} : '0;
                end
              end
              tcq_pkg::FUNC_CANCEL: begin
                if (r_bit != '0 && om != '0) res_status <= tcq_pkg::ST_OK;
              end
              tcq_pkg::FUNC_CLEAR: begin
                res_status <= tcq_pkg::ST_OK;
              end
              default: begin
              end
            endcase
          end
        end
        S_Q1: begin
          q_prod <= PW'(q_k) * PW'(iv_active);
          if (q_base < last_pop) q_base <= last_pop;
          state <= S_Q2;
        end
        S_Q2: begin
          res_status <= tcq_pkg::ST_OK;
          res_time   <= q_sum[64] ? '1 : q_sum[63:0];
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'd0, (count == '0), res_time, 16'(res_owners), res_auto,
                         32'(res_key), res_status};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

@@ sv/tcq_cell.sv @@
`default_nettype none
module tcq_cell #(
  parameter int KW = 32,
  parameter int OW = 16,
  parameter int CW = 6,
  parameter int IDX = 0
) (
  input  wire logic            clk,
  input  wire tcq_pkg::cell_op_t op,
  input  wire logic [KW-1:0]   new_key,
  input  wire logic            new_auto,
  input  wire logic [OW-1:0]   new_owners,
  input  wire logic [KW-1:0]   left_key,
  input  wire logic            left_auto,
  input  wire logic [OW-1:0]   left_owners,
  input  wire logic [KW-1:0]   right_key,
  input  wire logic            right_auto,
  input  wire logic [OW-1:0]   right_owners,
  input  wire logic [KW-1:0]   req_key,
  input  wire logic [OW-1:0]   req_bit,
  input  wire logic [CW-1:0]   count,
  output logic [KW-1:0]        key,
  output logic                 auto_flag,
  output logic [OW-1:0]        owners,
  output logic                 key_match,
  output logic                 owner_match,
  output logic                 auto_valid
);
  logic live;

  assign live        = CW'(IDX) < count;
  assign key_match   = live && (key == req_key);
  assign owner_match = live && ((owners & req_bit) != '0);
  assign auto_valid  = live && auto_flag;

  always_ff @(posedge clk) begin
    unique case (op)
      tcq_pkg::OP_NEW: begin
        key       <= new_key;
        auto_flag <= new_auto;
        owners    <= new_owners;
      end
      tcq_pkg::OP_LEFT: begin
        key       <= left_key;
        auto_flag <= left_auto;
        owners    <= left_owners;
      end
      tcq_pkg::OP_RIGHT: begin
        key       <= right_key;
        auto_flag <= right_auto;
        owners    <= right_owners;
      end
      tcq_pkg::OP_OWN: begin
        owners    <= new_owners;
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

@@ sv/tcq_checker.sv @@
`default_nettype none
module tcq_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [119:0] m_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] <= tcq_pkg::ST_FULL)
    else $error("undefined status code");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second transfer accepted while busy");

  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == tcq_pkg::ST_FULL |-> !m_tdata[115])
    else $error("full status with empty queue");
endmodule

bind two_class_dedupe_rate_limited_queue tcq_checker u_tcq_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  localparam int DEPTH = 32;
  localparam logic CFG_ACTIVE = 1'b0;
  localparam logic CFG_PASSIVE = 1'b1;
  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
  localparam int STALL_LIMIT = 4000;
  localparam int DIR_ROWS = 21;
  localparam int EXP_DEPTH = 16;

  localparam logic [2:0] F_ADD    = tcq_pkg::FUNC_ADD;
  localparam logic [2:0] F_POP    = tcq_pkg::FUNC_POP;
  localparam logic [2:0] F_QUERY  = tcq_pkg::FUNC_QUERY;
  localparam logic [2:0] F_CANCEL = tcq_pkg::FUNC_CANCEL;
  localparam logic [2:0] F_CLEAR  = tcq_pkg::FUNC_CLEAR;
  localparam logic [1:0] S_OK     = tcq_pkg::ST_OK;
  localparam logic [1:0] S_NONE   = tcq_pkg::ST_NONE;
  localparam logic [1:0] S_FULL   = tcq_pkg::ST_FULL;

  typedef struct {
    logic [2:0] func;
    logic [31:0] key;
    logic aut;
    logic [3:0] owner;
    logic present;
    logic [63:0] now;
    logic passive;
    bit typed;
    logic [1:0] t_status;
    logic t_empty;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [31:0] key;
    logic aut;
    logic [15:0] owners;
    logic [63:0] stime;
    logic empty;
  } resp_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [103:0] s_tdata;
  logic [2:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [119:0] m_tdata;
  logic cfg_we;
  logic cfg_addr;
  logic [31:0] cfg_data;

  logic [31:0] q_key [DEPTH];
  logic q_auto [DEPTH];
  logic [15:0] q_owners [DEPTH];
  int q_count;
  logic [63:0] last_pop;
  logic [63:0] iv_active;
  logic [63:0] iv_passive;

  resp_t exp_fifo [EXP_DEPTH];
  int exp_wr;
  int exp_rd;
  int mismatches;
  int checked;
  int quiet_cycles;
  bit no_idle;
  bit hold_done;
  logic [31:0] key_pool [40];
  logic [63:0] tick;
  req_t dir_tab [DIR_ROWS];

  two_class_dedupe_rate_limited_queue i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void result_store(resp_t r);
    exp_fifo[exp_wr % EXP_DEPTH] = r;
    exp_wr++;
  endfunction

  function automatic resp_t result_fetch();
    resp_t r;
    r = exp_fifo[exp_rd % EXP_DEPTH];
    exp_rd++;
    return r;
  endfunction

  function automatic void drop_entry(int pos);
    for (int i = pos; i < q_count - 1; i++) begin
      q_key[i] = q_key[i + 1];
      q_auto[i] = q_auto[i + 1];
      q_owners[i] = q_owners[i + 1];
    end
    q_count--;
  endfunction

  function automatic void place_entry(int pos, logic [31:0] k, logic a, logic [15:0] o);
    for (int i = q_count; i > pos; i--) begin
      q_key[i] = q_key[i - 1];
      q_auto[i] = q_auto[i - 1];
      q_owners[i] = q_owners[i - 1];
    end
    q_key[pos] = k;
    q_auto[pos] = a;
    q_owners[pos] = o;
    q_count++;
  endfunction

  function automatic int first_auto_slot();
    for (int i = 0; i < q_count; i++)
      if (q_auto[i]) return i;
    return q_count;
  endfunction

  function automatic logic [1:0] queue_request(logic [31:0] k, logic a, logic [15:0] bitm);
    logic [15:0] merged;
    for (int i = 0; i < q_count; i++) begin
      if (q_key[i] == k) begin
        merged = q_owners[i] | bitm;
        q_owners[i] = merged;
        if (!a && q_auto[i]) begin
          drop_entry(i);
          place_entry(first_auto_slot(), k, 1'b0, merged);
          return S_OK;
        end
        return S_NONE;
      end
    end
    if (q_count >= DEPTH) return S_FULL;
    place_entry(a ? q_count : first_auto_slot(), k, a, bitm);
    return S_OK;
  endfunction

  function automatic resp_t serve_request(req_t r);
    resp_t res;
    logic [15:0] bitm;
    logic [63:0] iv;
    logic [63:0] x;
    res = '{status: S_NONE, key: '0, aut: 1'b0, owners: '0, stime: '0, empty: 1'b0};
    bitm = 16'd1 << r.owner;
    case (r.func)
      F_ADD: res.status = queue_request(r.key, r.aut, bitm);
      F_POP: begin
        iv = r.passive ? iv_passive : iv_active;
        if (r.now > last_pop && (r.now - last_pop) > iv && q_count > 0) begin
          res.key = q_key[0];
          res.aut = q_auto[0];
          res.owners = q_owners[0];
          drop_entry(0);
          last_pop = r.now;
          res.status = S_OK;
        end
      end
      F_QUERY: begin
        if (!r.present) begin
          res.stime = tcq_pkg::NO_OWNER_TIME;
          res.status = S_OK;
        end else begin
          x = r.now >= iv_active ? r.now - iv_active : 64'd0;
          if (last_pop > x) x = last_pop;
          for (int i = 0; i < q_count; i++) begin
            x = (x > ~64'd0 - iv_active) ? ~64'd0 : x + iv_active;
            if ((q_owners[i] & bitm) != 0) begin
              res.stime = x;
              res.status = S_OK;
              break;
            end
          end
        end
      end
      F_CANCEL: begin
        for (int i = 0; i < q_count; i++) begin
          if ((q_owners[i] & bitm) != 0) begin
            q_owners[i] &= ~bitm;
            if (q_owners[i] == 0) drop_entry(i);
            res.status = S_OK;
            break;
          end
        end
      end
      F_CLEAR: begin
        q_count = 0;
        res.status = S_OK;
      end
      default: ;
    endcase
    res.empty = (q_count == 0);
    if (r.typed) begin
      res.status = r.t_status;
      res.empty = r.t_empty;
    end
    return res;
  endfunction

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ACTIVE) iv_active = {32'd0, val};
    else iv_passive = {32'd0, val};
  endtask

  task automatic wait_drained();
    wait (exp_wr == exp_rd);
    repeat (10) @(negedge clk);
  endtask

  task automatic send_request(req_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= r.func;
    s_tdata <= {1'b0, r.passive, r.now, r.present, r.owner, r.aut, r.key};
    do @(posedge clk); while (!s_tready);
    result_store(serve_request(r));
  endtask

  function automatic req_t random_request();
    req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.typed = 1'b0;
    r.t_status = S_OK;
    r.t_empty = 1'b0;
    if (pick < 45) r.func = F_ADD;
    else if (pick < 70) r.func = F_POP;
    else if (pick < 84) r.func = F_QUERY;
    else if (pick < 96) r.func = F_CANCEL;
    else if (pick < 98) r.func = F_CLEAR;
    else r.func = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
    r.key = $urandom_range(0, 15) == 0 ? $urandom() : key_pool[$urandom_range(0, 39)];
    r.aut = 1'($urandom_range(0, 1));
    r.owner = 4'($urandom_range(0, 15));
    r.present = $urandom_range(0, 9) != 0;
    if ($urandom_range(0, 29) == 0) tick = {$urandom(), $urandom()};
    else tick = tick + 64'($urandom_range(0, 1500));
    r.now = tick;
    r.passive = 1'($urandom_range(0, 1));
    return r;
  endfunction

  initial begin
    logic [31:0] act_set [4];
    logic [31:0] pas_set [4];
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = F_ADD;
    cfg_we = 1'b0;
    cfg_addr = CFG_ACTIVE;
    cfg_data = '0;
    q_count = 0;
    exp_wr = 0;
    exp_rd = 0;
    last_pop = '0;
    iv_active = 64'd2000;
    iv_passive = 64'd2000;
    no_idle = 1'b0;
    tick = 64'd3000;
    for (int i = 0; i < 40; i++) key_pool[i] = (i < 20) ? 32'(i) : $urandom();
    key_pool[20] = 32'hFFFF_FFFF;
    dir_tab = '{
      '{F_POP,    32'h0, 1'b0, 4'd0,  1'b1, 64'd5000, 1'b0, 1'b1, S_NONE, 1'b1},
      '{F_QUERY,  32'h0, 1'b0, 4'd0,  1'b0, 64'd0,    1'b0, 1'b1, S_OK,   1'b1},
      '{F_QUERY,  32'h0, 1'b0, 4'd5,  1'b1, 64'd0,    1'b0, 1'b1, S_NONE, 1'b1},
      '{F_CANCEL, 32'h0, 1'b0, 4'd5,  1'b1, 64'd0,    1'b0, 1'b1, S_NONE, 1'b1},
      '{F_ADD,    32'h0, 1'b0, 4'd0,  1'b1, 64'd0,    1'b0, 1'b1, S_OK,   1'b0},
      '{F_ADD, 32'hFFFF_FFFF, 1'b1, 4'd15, 1'b1, 64'd0, 1'b0, 1'b1, S_OK, 1'b0},
      '{F_ADD,    32'h7, 1'b1, 4'd2,  1'b1, 64'd0,    1'b0, 1'b1, S_OK,   1'b0},
      '{F_ADD,    32'h0, 1'b1, 4'd3,  1'b1, 64'd0,    1'b0, 1'b1, S_NONE, 1'b0},
      '{F_ADD, 32'hFFFF_FFFF, 1'b0, 4'd1, 1'b1, 64'd0, 1'b0, 1'b1, S_OK, 1'b0},
      '{F_ADD,    32'h9, 1'b0, 4'd4,  1'b1, 64'd0,    1'b0, 1'b0, S_OK,   1'b0},
      '{F_QUERY,  32'h0, 1'b0, 4'd2,  1'b1, ~64'd0,   1'b0, 1'b0, S_OK,   1'b0},
      '{F_QUERY,  32'h0, 1'b0, 4'd15, 1'b1, 64'd100,  1'b0, 1'b0, S_OK,   1'b0},
      '{F_QUERY,  32'h0, 1'b0, 4'd9,  1'b1, 64'd100,  1'b0, 1'b1, S_NONE, 1'b0},
      '{F_CANCEL, 32'h0, 1'b0, 4'd0,  1'b1, 64'd0,    1'b0, 1'b0, S_OK,   1'b0},
      '{F_POP,    32'h0, 1'b0, 4'd0,  1'b1, 64'd2000, 1'b0, 1'b1, S_NONE, 1'b0},
      '{F_POP,    32'h0, 1'b0, 4'd0,  1'b1, 64'd2001, 1'b0, 1'b0, S_OK,   1'b0},
      '{F_POP,    32'h0, 1'b0, 4'd0,  1'b1, ~64'd0,   1'b1, 1'b0, S_OK,   1'b0},
      '{F_POP,    32'h0, 1'b0, 4'd0,  1'b1, ~64'd0,   1'b1, 1'b1, S_NONE, 1'b0},
      '{FUNC_SPARE_LO, 32'h0, 1'b0, 4'd0, 1'b1, 64'd0, 1'b0, 1'b1, S_NONE, 1'b0},
      '{FUNC_SPARE_HI, 32'h0, 1'b0, 4'd0, 1'b1, 64'd0, 1'b0, 1'b1, S_NONE, 1'b0},
      '{F_CLEAR,  32'h0, 1'b0, 4'd0,  1'b1, 64'd0,    1'b0, 1'b1, S_OK,   1'b1}
    };
    act_set = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd0};
    pas_set = '{32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int i = 0; i < DIR_ROWS; i++) send_request(dir_tab[i]);
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait_drained();
        if (ph == 4) begin
          act_set[3] = $urandom_range(0, 5000);
          pas_set[3] = $urandom_range(0, 5000);
        end
        write_reg(CFG_ACTIVE, act_set[ph - 1]);
        write_reg(CFG_PASSIVE, pas_set[ph - 1]);
        tick = 64'd1000;
      end
      for (int n = 0; n < 126; n++) begin
        if (n % 40 == 0) no_idle = $urandom_range(0, 2) == 0;
        if (ph == 2 && n == 60) begin
          @(negedge clk);
          s_tvalid <= 1'b0;
          wait (exp_wr == exp_rd);
        end
        send_request(random_request());
      end
    end
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (exp_wr == exp_rd);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    resp_t exp_r;
    resp_t got;
    int stall;
    m_tready = 1'b0;
    mismatches = 0;
    checked = 0;
    hold_done = 1'b0;
    wait (!rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (!hold_done && checked == 250) begin
        stall = 300;
        hold_done = 1'b1;
      end
      if (stall > 0) begin
        @(negedge clk);
        m_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got.status = m_tdata[1:0];
      got.key = m_tdata[33:2];
      got.aut = m_tdata[34];
      got.owners = m_tdata[50:35];
      got.stime = m_tdata[114:51];
      got.empty = m_tdata[115];
      checked++;
      if (exp_wr == exp_rd) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: %h", m_tdata);
      end else begin
        exp_r = result_fetch();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: status %0d/%0d key %h/%h auto %b/%b owners %h/%h",
                     checked, exp_r.status, got.status, exp_r.key, got.key,
                     exp_r.aut, got.aut, exp_r.owners, got.owners,
                     " time %h/%h empty %b/%b",
                     exp_r.stime, got.stime, exp_r.empty, got.empty);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end
endmodule
